// ===== sv/nearest_crossing_tie_select_top_assert.svh =====
// Assertion macros for the nearest crossing selector checks.
`ifndef NEAREST_CROSSING_TIE_SELECT_TOP_ASSERT_SVH
`define NEAREST_CROSSING_TIE_SELECT_TOP_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define NCTS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, quiet during reset.
`define NCTS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/ncts_pkg.sv =====
`default_nettype none
package ncts_pkg;

	localparam int DIST_W = 33;
	localparam int SUM_W  = 66;

	// Request opcodes
	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_CROSS  = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;
	localparam logic [1:0] OP_SPARE  = 2'd3;

	// Verdict codes
	localparam logic [1:0] V_SELECTED = 2'd0;
	localparam logic [1:0] V_NONE     = 2'd1;
	localparam logic [1:0] V_OVERLAP  = 2'd2;
	localparam logic [1:0] V_AMBIG    = 2'd3;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
		logic               overlap_flag;
		logic [15:0]        unresolved_in;
		logic [15:0]        ambiguous_in;
		logic               edge_contact;
		logic signed [31:0] transversality;
		logic signed [31:0] rel_threshold;
	} ncts_req_t;

	typedef struct packed {
		logic [1:0]        verdict;
		logic [15:0]       crossing_total;
		logic              several_crossings;
		logic [5:0]        chosen_index;
		logic [6:0]        nearest_ties;
		logic [DIST_W-1:0] nearest_distance;
		logic              chosen_edge_contact;
		logic              chosen_reliable;
		logic [15:0]       unresolved_out;
		logic [15:0]       ambiguous_out;
		logic              overflow;
	} ncts_res_t;

endpackage
`default_nettype wire

// ===== sv/nearest_crossing_tie_select_top.sv =====
// Start requests are taken in idle and leave busy low.
// Crossing requests square the differences on one 32x32 multiplier, launch the bit-serial
// square root, store the root and return to idle; beyond capacity they are only counted.
// Finish requests scan the distance memory for entries within tolerance of the nearest,
// and go straight to emit when the verdict is overlap or no crossing. done pulses once, no stall.
// Reset (arst_n low) clears all control state; memory contents stay undefined.
`default_nettype none
module nearest_crossing_tie_select_top #(
	parameter int MAX_CROSSINGS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  ncts_pkg::ncts_req_t req,
	output logic                busy,
	output logic                done,
	output ncts_pkg::ncts_res_t res,
	input  logic                cfg_we,
	input  logic [31:0]         cfg_wdata
);
	import ncts_pkg::*;

	localparam int AW = (MAX_CROSSINGS > 1) ? $clog2(MAX_CROSSINGS) : 1;
	localparam int PW = $clog2(MAX_CROSSINGS + 1);
	localparam int MW = DIST_W + 2;
	localparam logic [15:0] MAX_W = 16'(MAX_CROSSINGS);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQ   = 3'd1;
	localparam logic [2:0] ST_ROOT = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]        state_q;
	logic [31:0]       tol_q;
	logic [31:0]       qx_q, qy_q, qz_q;
	logic              overlap_q;
	logic [15:0]       unres_q, ambig_q;
	logic [15:0]       cnt_q;
	logic [DIST_W-1:0] min_q;
	logic [31:0]       cx_q, cy_q, cz_q;
	logic [1:0]        flags_q;
	logic [1:0]        step_q;
	logic [63:0]       prod_s1;
	logic              mh_s1;
	logic [SUM_W-1:0]  acc_q;
	logic              sq_go_q;
	logic              sq_done;
	logic [DIST_W-1:0] sq_root;
	logic [MW-1:0]     mem [MAX_CROSSINGS];
	logic [PW-1:0]     ptr_q;
	logic              rd_vld_s1;
	logic [AW-1:0]     rd_idx_s1;
	logic [MW-1:0]     rd_data_s1;
	logic [PW-1:0]     ties_q;
	logic [AW-1:0]     first_q;
	logic [1:0]        fflags_q;
	logic              done_q;
	ncts_res_t         res_q;

	logic              accept;
	logic [31:0]       c_sel, q_sel;
	logic [32:0]       diff, mag;
	logic [PW-1:0]     stored;
	logic              rd_en;
	logic              wr_en;
	logic              tie;
	logic              rel_in;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign rel_in = (req.rel_threshold > 32'sd0) &&
		(req.transversality > req.rel_threshold);
	assign stored = (cnt_q < MAX_W) ? PW'(cnt_q) : PW'(MAX_CROSSINGS);
	assign rd_en  = (state_q == ST_SCAN) && (ptr_q < stored);
	assign wr_en  = (state_q == ST_ROOT) && sq_done;
	assign tie    = ({1'b0, rd_data_s1[DIST_W-1:0]} - {1'b0, min_q}) <=
		{2'b00, tol_q};

	// Select the coordinate pair for this multiplier step
	always_comb begin
		case (step_q)
			2'd0: begin c_sel = cx_q; q_sel = qx_q; end
			2'd1: begin c_sel = cy_q; q_sel = qy_q; end
			2'd2: begin c_sel = cz_q; q_sel = qz_q; end
			default: begin c_sel = cz_q; q_sel = qz_q; end
		endcase
		diff = {c_sel[31], c_sel} - {q_sel[31], q_sel};
		mag  = diff[32] ? 33'(-diff) : diff;
	end

	// Hold the tolerance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	// Sequence requests through squares, root, store, scan and emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			qx_q      <= '0;
			qy_q      <= '0;
			qz_q      <= '0;
			overlap_q <= 1'b0;
			unres_q   <= '0;
			ambig_q   <= '0;
			cnt_q     <= '0;
			min_q     <= '1;
			step_q    <= '0;
			sq_go_q   <= 1'b0;
			ptr_q     <= '0;
			rd_vld_s1 <= 1'b0;
			ties_q    <= '0;
			done_q    <= 1'b0;
		end else begin
			sq_go_q <= 1'b0;
			done_q  <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.opcode)
							OP_START: begin
								qx_q      <= req.coord_x;
								qy_q      <= req.coord_y;
								qz_q      <= req.coord_z;
								overlap_q <= req.overlap_flag;
								unres_q   <= req.unresolved_in;
								ambig_q   <= req.ambiguous_in;
								cnt_q     <= '0;
								min_q     <= '1;
							end
							OP_CROSS: begin
								if (cnt_q < MAX_W) begin
									step_q  <= '0;
									state_q <= ST_SQ;
								end else if (cnt_q != 16'hFFFF) begin
									cnt_q <= cnt_q + 16'd1;
								end
							end
							OP_FINISH: begin
								if (overlap_q || cnt_q == '0) begin
									state_q <= ST_EMIT;
								end else begin
									ptr_q     <= '0;
									ties_q    <= '0;
									rd_vld_s1 <= 1'b0;
									state_q   <= ST_SCAN;
								end
							end
							default: ;
						endcase
					end
				end
				ST_SQ: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						sq_go_q <= 1'b1;
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (sq_done) begin
						if (sq_root < min_q) begin
							min_q <= sq_root;
						end
						cnt_q   <= cnt_q + 16'd1;
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					rd_vld_s1 <= rd_en;
					if (rd_en) begin
						ptr_q <= ptr_q + PW'(1);
					end
					if (rd_vld_s1 && tie) begin
						ties_q <= ties_q + PW'(1);
					end
					if (!rd_en && !rd_vld_s1) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Capture the crossing point and its flags
	always_ff @(posedge clk) begin
		if (accept && req.opcode == OP_CROSS) begin
			cx_q    <= req.coord_x;
			cy_q    <= req.coord_y;
			cz_q    <= req.coord_z;
			flags_q <= {rel_in, req.edge_contact};
		end
	end

	// Square one difference per cycle and accumulate the previous square
	always_ff @(posedge clk) begin
		if (state_q == ST_SQ) begin
			prod_s1 <= mag[31:0] * mag[31:0];
			mh_s1   <= mag[32];
			if (step_q == 2'd0) begin
				acc_q <= '0;
			end else begin
				acc_q <= acc_q + {2'b00, prod_s1} + {1'b0, mh_s1, 64'd0};
			end
		end
	end

	// Remember the first tied entry
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_idx_s1 <= AW'(ptr_q);
		end
		if (state_q == ST_SCAN && rd_vld_s1 && tie && ties_q == '0) begin
			first_q  <= rd_idx_s1;
			fflags_q <= rd_data_s1[MW-1 -: 2];
		end
	end

	// Distance and flag memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[AW'(cnt_q)] <= {flags_q, sq_root};
		end
		if (rd_en) begin
			rd_data_s1 <= mem[AW'(ptr_q)];
		end
	end

	// Form the verdict
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT) begin
			res_q.crossing_total      <= cnt_q;
			res_q.several_crossings   <= cnt_q > 16'd1;
			res_q.unresolved_out      <= unres_q;
			res_q.ambiguous_out       <= ambig_q;
			res_q.overflow            <= cnt_q > MAX_W;
			res_q.chosen_index        <= '0;
			res_q.chosen_edge_contact <= 1'b0;
			res_q.chosen_reliable     <= 1'b0;
			res_q.nearest_ties        <= '0;
			res_q.nearest_distance    <= '0;
			if (overlap_q) begin
				res_q.verdict <= V_OVERLAP;
			end else if (cnt_q == '0) begin
				res_q.verdict <= V_NONE;
			end else begin
				res_q.nearest_ties     <= 7'(ties_q);
				res_q.nearest_distance <= min_q;
				if (ties_q == PW'(1)) begin
					res_q.verdict             <= V_SELECTED;
					res_q.chosen_index        <= 6'(first_q);
					res_q.chosen_edge_contact <= fflags_q[0];
					res_q.chosen_reliable     <= fflags_q[1];
				end else begin
					res_q.verdict <= V_AMBIG;
				end
			end
		end
	end

	ncts_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (sq_go_q),
		.rad    (acc_q),
		.done   (sq_done),
		.root   (sq_root)
	);

	assign done = done_q;
	assign res  = res_q;

endmodule
`default_nettype wire

// ===== sv/ncts_sqrt.sv =====
`default_nettype none
module ncts_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      go,
	input  logic [ncts_pkg::SUM_W-1:0] rad,
	output logic                      done,
	output logic [ncts_pkg::DIST_W-1:0] root
);
	import ncts_pkg::*;

	logic [SUM_W-1:0]  rad_q;
	logic [34:0]       rem_q;
	logic [DIST_W-1:0] root_q;
	logic [5:0]        cnt_q;
	logic              run_q;
	logic              done_q;
	logic [36:0]       rem_n;
	logic [36:0]       trial;
	logic              fits;

	// One root bit per cycle: bring down two radicand bits, try root*4+1
	assign rem_n = {rem_q, rad_q[SUM_W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign fits  = rem_n >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= 6'(DIST_W - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	// Hold the working registers of the digit recurrence
	always_ff @(posedge clk) begin
		if (go) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q  <= {rad_q[SUM_W-3:0], 2'b00};
			rem_q  <= fits ? 35'(rem_n - trial) : rem_n[34:0];
			root_q <= {root_q[DIST_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

// ===== sv/ncts_checker.sv =====
`default_nettype none
`include "nearest_crossing_tie_select_top_assert.svh"
module ncts_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input ncts_pkg::ncts_req_t req,
	input ncts_pkg::ncts_res_t res
);
	import ncts_pkg::*;

	// Result appears only once the block is free again
	`NCTS_ASSERT_IMP(a_done_idle, done, !busy, "result while busy")
	// Result always follows a busy cycle
	`NCTS_ASSERT_IMP(a_done_after_busy, done, $past(busy), "result without work")
	// Finish request always occupies the block
	`NCTS_ASSERT_NXT(a_finish_busy, start && !busy && req.opcode == OP_FINISH, busy,
		"finish request not taken")
	// Selection means exactly one tie
	`NCTS_ASSERT_IMP(a_sel_one_tie, done && res.verdict == V_SELECTED,
		res.nearest_ties == 7'd1, "selected without single tie")

endmodule

bind nearest_crossing_tie_select_top ncts_checker u_ncts_checker (.*);
`default_nettype wire
